// ----- rtl/sqt_pkg.sv -----
// shared types, constants and helpers of the search query tokenizer
package sqt_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W      = $clog2(MAX_RESULTS);

  localparam logic [7:0]  QUOTE_CH  = 8'h22;
  localparam logic [7:0]  BAR_CH    = 8'h7C;
  localparam logic [15:0] LEN_RESET = 16'd4096;

  localparam int AND_LEN = 5;
  localparam int OR_LEN  = 4;
  // " AND " and " OR "
  localparam logic [7:0] AND_TXT [AND_LEN] = '{8'h20, 8'h41, 8'h4E, 8'h44, 8'h20};
  localparam logic [7:0] OR_TXT  [OR_LEN]  = '{8'h20, 8'h4F, 8'h52, 8'h20};

  typedef enum logic [1:0] {
    MODE_GAP    = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_PHRASE = 2'd2,
    MODE_QPEND  = 2'd3
  } lex_mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_UNCLOSED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       query_done;
    logic [1:0] status;
  } result_t;

  // results caused by one accepted item, slot 0 goes out first
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] entry;
    logic    [CNT_W-1:0]       count;
  } burst_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic result_t mk_byte(input logic [7:0] b);
    result_t r;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.query_done = 1'b0;
    r.status     = ST_OK;
    return r;
  endfunction

  function automatic result_t mk_final(input status_t st);
    result_t r;
    r.out_byte   = 8'h00;
    r.byte_valid = 1'b0;
    r.query_done = 1'b1;
    r.status     = st;
    return r;
  endfunction

endpackage

// ----- rtl/sqt_ifs.sv -----
// channel interfaces of the search query tokenizer

interface sqt_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;
  modport source (output valid, action, in_byte, input ready);
  modport sink   (input valid, action, in_byte, output ready);
endinterface

interface sqt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       query_done;
  logic [1:0] status;
  modport source (output valid, out_byte, byte_valid, query_done, status, input ready);
  modport sink   (input valid, out_byte, byte_valid, query_done, status, output ready);
endinterface

interface sqt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_query_len;
  modport source (output valid, max_query_len, input ready);
  modport sink   (input valid, max_query_len, output ready);
endinterface

// ----- rtl/sqt_lexer.sv -----
// lexer state, length limit register and per-item result builder
module sqt_lexer import sqt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sqt_cfg_if.sink       cfg_ch,
  input  logic          take,
  input  logic          action,
  input  logic [7:0]    in_byte,
  output burst_t        burst
);

  logic [15:0] max_len_r;
  lex_mode_t   mode_r, mode_nxt;
  logic        need_and_r, need_and_nxt;
  logic        seen_r, seen_nxt;
  logic [15:0] kept_r, kept_nxt;

  // emission plan
  logic       close_q, or_t, and_t, open_q, chr, fin;
  status_t    st;
  logic       go_out, was_word;
  logic [CNT_W-1:0] n;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= LEN_RESET;
      mode_r     <= MODE_GAP;
      need_and_r <= 1'b0;
      seen_r     <= 1'b0;
      kept_r     <= '0;
    end else begin
      if (cfg_ch.valid) begin
        max_len_r <= cfg_ch.max_query_len;
      end
      mode_r     <= mode_nxt;
      need_and_r <= need_and_nxt;
      seen_r     <= seen_nxt;
      kept_r     <= kept_nxt;
    end
  end

  // next state and emission plan
  always_comb begin
    mode_nxt     = mode_r;
    need_and_nxt = need_and_r;
    seen_nxt     = seen_r;
    kept_nxt     = kept_r;
    close_q      = 1'b0;
    or_t         = 1'b0;
    and_t        = 1'b0;
    open_q       = 1'b0;
    chr          = 1'b0;
    fin          = 1'b0;
    st           = ST_OK;
    go_out       = 1'b0;
    was_word     = 1'b0;
    if (take) begin
      if (action) begin
        fin = 1'b1;
        if (!seen_r) begin
          st = ST_EMPTY;
        end else if (mode_r == MODE_PHRASE) begin
          st = ST_UNCLOSED;
        end else if (mode_r inside {MODE_QPEND, MODE_WORD}) begin
          close_q = 1'b1;
        end
        mode_nxt     = MODE_GAP;
        need_and_nxt = 1'b0;
        seen_nxt     = 1'b0;
        kept_nxt     = '0;
      end else if (!((!seen_r && is_blank(in_byte)) || (kept_r >= max_len_r))) begin
        seen_nxt = 1'b1;
        kept_nxt = kept_r + 16'd1;
        case (mode_r)
          MODE_PHRASE: begin
            if (in_byte == QUOTE_CH) begin
              mode_nxt = MODE_QPEND;
            end else begin
              chr = 1'b1;
            end
          end
          MODE_QPEND: begin
            close_q = 1'b1;
            if (in_byte == QUOTE_CH) begin
              // doubled quote stays doubled inside the phrase
              chr      = 1'b1;
              mode_nxt = MODE_PHRASE;
            end else begin
              go_out = 1'b1;
            end
          end
          default: begin
            go_out   = 1'b1;
            was_word = (mode_r == MODE_WORD);
          end
        endcase
        if (go_out) begin
          if (in_byte == QUOTE_CH) begin
            close_q      = close_q | was_word;
            and_t        = need_and_r;
            open_q       = 1'b1;
            need_and_nxt = 1'b1;
            mode_nxt     = MODE_PHRASE;
          end else if (in_byte == BAR_CH) begin
            close_q      = close_q | was_word;
            or_t         = 1'b1;
            need_and_nxt = 1'b0;
            mode_nxt     = MODE_GAP;
          end else if (is_blank(in_byte)) begin
            close_q  = close_q | was_word;
            mode_nxt = MODE_GAP;
          end else begin
            if (!was_word) begin
              and_t        = need_and_r;
              open_q       = 1'b1;
              need_and_nxt = 1'b1;
            end
            mode_nxt = MODE_WORD;
            chr      = 1'b1;
          end
        end
      end
    end
  end

  // lay out the planned results in emission order
  always_comb begin
    burst.entry = '0;
    n = '0;
    if (close_q) begin
      burst.entry[n[SLOT_W-1:0]] = mk_byte(QUOTE_CH);
      n = n + CNT_W'(1);
    end
    if (or_t) begin
      for (int k = 0; k < OR_LEN; k++) begin
        burst.entry[n[SLOT_W-1:0]] = mk_byte(OR_TXT[k]);
        n = n + CNT_W'(1);
      end
    end
    if (and_t) begin
      for (int k = 0; k < AND_LEN; k++) begin
        burst.entry[n[SLOT_W-1:0]] = mk_byte(AND_TXT[k]);
        n = n + CNT_W'(1);
      end
    end
    if (open_q) begin
      burst.entry[n[SLOT_W-1:0]] = mk_byte(QUOTE_CH);
      n = n + CNT_W'(1);
    end
    if (chr) begin
      burst.entry[n[SLOT_W-1:0]] = mk_byte(in_byte);
      n = n + CNT_W'(1);
    end
    if (fin) begin
      burst.entry[n[SLOT_W-1:0]] = mk_final(st);
      n = n + CNT_W'(1);
    end
    burst.count = n;
  end

endmodule

// ----- rtl/sqt_emitter.sv -----
// result buffer that drains one result per cycle onto the output channel while out_ch is ready
module sqt_emitter import sqt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  burst_t   burst,
  output logic     ld_ok,
  sqt_out_if.source out_ch
);

  result_t          slot_r [MAX_RESULTS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop, fill;

  assign pop   = out_ch.valid && out_ch.ready;
  assign ld_ok = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign fill  = load && (burst.count != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (fill) begin
      cnt_nxt = burst.count;
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        slot_r[i] <= burst.entry[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
    end
  end

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.out_byte   = slot_r[0].out_byte;
  assign out_ch.byte_valid = slot_r[0].byte_valid;
  assign out_ch.query_done = slot_r[0].query_done;
  assign out_ch.status     = slot_r[0].status;

  a_fill_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    fill |-> (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && pop))
    else $error("result buffer reloaded while results still pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("result count beyond buffer depth");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !fill && (cnt_r > CNT_W'(1))) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("result buffer did not drain by one");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.byte_valid != out_ch.query_done)
                     && (out_ch.query_done || (out_ch.status == ST_OK)))
    else $error("result is neither a plain byte nor a final status");

endmodule

// ----- rtl/search_query_tokenizer.sv -----
// top level of the streaming search query tokenizer
//
// in_ch carries one query byte (action 0) or an end marker (action 1) per item.
// out_ch carries the rewritten query one byte per item; the end marker yields
// a final item with query_done set and a status (ok, empty, unclosed quote).
// On a non-ok status the bytes already sent for that query are to be dropped.
// cfg_ch writes max_query_len and is always ready; the user must write it only
// while the block is idle; the block itself does not enforce this.
// Latency: the first result of an item is offered the cycle after acceptance.
// Throughput: one item per cycle while each item yields at most one result and
// out_ch is ready. An item yielding k results (up to 8, e.g. a closing quote
// plus " AND ", the opening quote and the byte) holds in_ch until the last of
// them is taken; the result buffer drains one per cycle while out_ch is ready.
// Items yielding nothing (skipped blanks, bytes past the limit) load nothing.
//
// Reset (rst_n low, synchronous): limit back to 4096, lexer between terms,
// result buffer empty. When out_ch stalls, the buffered results hold and
// in_ch.ready stays low until the last of them is being taken.
module search_query_tokenizer import sqt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sqt_in_if.sink    in_ch,
  sqt_out_if.source out_ch,
  sqt_cfg_if.sink   cfg_ch
);

  logic   take;
  logic   ld_ok;
  burst_t burst;

  // input is taken whenever the buffer is empty or its last result leaves now
  assign in_ch.ready = ld_ok;
  assign take        = in_ch.valid && ld_ok;

  // lexer: state update and result layout for the accepted item
  sqt_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .take    (take),
    .action  (in_ch.action),
    .in_byte (in_ch.in_byte),
    .burst   (burst)
  );

  // emitter: registered result buffer feeding out_ch
  sqt_emitter u_emitter (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (take),
    .burst  (burst),
    .ld_ok  (ld_ok),
    .out_ch (out_ch)
  );

endmodule
